/* rtl/core/iopt_pkg.sv */
// Shared types, codes and constants of the I/O page table walker.
`timescale 1ns / 1ps
`default_nettype none
package iopt_pkg;

  localparam int DEF_TABLE_POOL = 64;
  localparam int DEF_LEVELS     = 4;
  localparam int DEF_MAX_PAGES  = 512;

  localparam int SLOT_W  = 9;
  localparam int LVL_W   = 3;
  localparam int FRAME_W = 40;
  localparam int VA_W    = 48;
  localparam int PA_W    = 52;
  localparam int CNT_W   = 10;

  localparam logic [1:0] OP_MAP   = 2'd0;
  localparam logic [1:0] OP_UNMAP = 2'd1;
  localparam logic [1:0] OP_XLATE = 2'd2;
  localparam logic [1:0] OP_BAD   = 2'd3;

  typedef struct packed {
    logic               perm_w;
    logic               perm_r;
    logic [LVL_W-1:0]   nxt;
    logic [FRAME_W-1:0] addr;
    logic               present;
  } ent_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_READ,
    ST_EVAL,
    ST_LEAF,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic clr_step;
    logic rd;
    logic descend;
    logic alloc;
    logic wr_leaf;
    logic next_page;
    logic set_result;
    logic set_err;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic       clr_last;
    logic       enable;
    logic [1:0] opcode;
    logic       misaligned;
    logic       count_zero;
    logic       count_one;
    logic       at_leaf;
    logic       level_two;
    logic       present;
    logic       link_ok;
    logic       pool_left;
    logic       out_free;
  } sts_t;

  // Slot index that a virtual address selects in a table of the given level.
  function automatic logic [SLOT_W-1:0] slot_index(input logic [VA_W-1:0] va,
                                                   input logic [LVL_W-1:0] level);
    logic [63:0] w;
    logic [6:0]  sh;
    sh = 7'd12 + 7'(level) * 7'd9 - 7'd9;
    w  = {16'b0, va} >> sh;
    return w[SLOT_W-1:0];
  endfunction

endpackage
`default_nettype wire

/* rtl/core/iopt_if.sv */
// Request and response channel interfaces of the I/O page table walker.
`timescale 1ns / 1ps
`default_nettype none
interface iopt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [47:0] io_virtual_address;
  logic [51:0] physical_address;
  logic [9:0]  page_count;
  logic        write_allowed;

  modport source (output valid, opcode, io_virtual_address, physical_address,
                  page_count, write_allowed, input ready);
  modport sink (input valid, opcode, io_virtual_address, physical_address,
                page_count, write_allowed, output ready);
endinterface

interface iopt_rsp_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [51:0] translated_address;

  modport source (output valid, status, translated_address, input ready);
  modport sink (input valid, status, translated_address, output ready);
endinterface
`default_nettype wire

/* rtl/core/iopt_ctrl.sv */
// Sequencer of the table walk: clearing pass, dispatch, level walk, leaf update.
`timescale 1ns / 1ps
`default_nettype none
module iopt_ctrl (
  input  wire               clk,
  input  wire               rst,
  input  wire               req_valid,
  output logic              req_ready,
  input  iopt_pkg::sts_t    sts,
  output iopt_pkg::cmd_t    cmd
);

  iopt_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= iopt_pkg::ST_CLEAR;
    else     state <= state_next;
  end

  always_comb begin
    logic grow;
    grow       = (sts.opcode == iopt_pkg::OP_MAP);
    cmd        = '0;
    state_next = state;
    req_ready  = 1'b0;
    unique case (state)
      iopt_pkg::ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_next = iopt_pkg::ST_IDLE;
      end
      iopt_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = iopt_pkg::ST_DISPATCH;
        end
      end
      iopt_pkg::ST_DISPATCH: begin
        priority if (!sts.enable || sts.opcode == iopt_pkg::OP_BAD) begin
          cmd.set_err = 1'b1;
          state_next  = iopt_pkg::ST_FINISH;
        end else if (sts.opcode == iopt_pkg::OP_MAP && sts.misaligned) begin
          cmd.set_err = 1'b1;
          state_next  = iopt_pkg::ST_FINISH;
        end else if (sts.opcode != iopt_pkg::OP_XLATE && sts.count_zero) begin
          state_next = iopt_pkg::ST_FINISH;
        end else begin
          state_next = iopt_pkg::ST_READ;
        end
      end
      iopt_pkg::ST_READ: begin
        cmd.rd     = 1'b1;
        state_next = iopt_pkg::ST_EVAL;
      end
      iopt_pkg::ST_EVAL: begin
        priority if (sts.at_leaf) begin
          // Only a translation reads the leaf entry itself.
          if (sts.present) cmd.set_result = 1'b1;
          state_next = iopt_pkg::ST_FINISH;
        end else if (sts.present && sts.link_ok) begin
          cmd.descend = 1'b1;
          state_next  = sts.level_two ? iopt_pkg::ST_LEAF : iopt_pkg::ST_READ;
        end else if (!sts.present && grow && sts.pool_left) begin
          cmd.alloc  = 1'b1;
          state_next = sts.level_two ? iopt_pkg::ST_LEAF : iopt_pkg::ST_READ;
        end else if (sts.opcode == iopt_pkg::OP_UNMAP) begin
          // No path for this page: skip it.
          cmd.next_page = 1'b1;
          state_next    = sts.count_one ? iopt_pkg::ST_FINISH : iopt_pkg::ST_READ;
        end else begin
          cmd.set_err = grow;
          state_next  = iopt_pkg::ST_FINISH;
        end
      end
      iopt_pkg::ST_LEAF: begin
        if (sts.opcode == iopt_pkg::OP_XLATE) begin
          cmd.rd     = 1'b1;
          state_next = iopt_pkg::ST_EVAL;
        end else begin
          cmd.wr_leaf   = 1'b1;
          cmd.next_page = 1'b1;
          state_next    = sts.count_one ? iopt_pkg::ST_FINISH : iopt_pkg::ST_READ;
        end
      end
      iopt_pkg::ST_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = iopt_pkg::ST_IDLE;
        end
      end
      default: state_next = iopt_pkg::ST_CLEAR;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/core/iopt_dpath.sv */
// Datapath of the walker: table memory, walk registers, allocator and result register.
`timescale 1ns / 1ps
`default_nettype none
module iopt_dpath #(
  parameter int TABLE_POOL = iopt_pkg::DEF_TABLE_POOL,
  parameter int LEVELS     = iopt_pkg::DEF_LEVELS,
  parameter int MAX_PAGES  = iopt_pkg::DEF_MAX_PAGES
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        cfg_write,
  input  wire                        cfg_data,
  input  wire  [1:0]                 opcode,
  input  wire  [iopt_pkg::VA_W-1:0]  io_virtual_address,
  input  wire  [iopt_pkg::PA_W-1:0]  physical_address,
  input  wire  [iopt_pkg::CNT_W-1:0] page_count,
  input  wire                        write_allowed,
  input  wire                        out_ready,
  output logic                       out_valid,
  output logic                       out_status,
  output logic [iopt_pkg::PA_W-1:0]  out_address,
  input  iopt_pkg::cmd_t             cmd,
  output iopt_pkg::sts_t             sts
);

  localparam int TBL_W  = (TABLE_POOL > 1) ? $clog2(TABLE_POOL) : 1;
  localparam int ADDR_W = TBL_W + iopt_pkg::SLOT_W;
  localparam int DEPTH  = TABLE_POOL * (1 << iopt_pkg::SLOT_W);

  iopt_pkg::ent_t mem [DEPTH];
  iopt_pkg::ent_t rdata;

  logic                       enable;
  logic [1:0]                 op;
  logic [iopt_pkg::VA_W-1:0]  va;
  logic [iopt_pkg::PA_W-1:0]  pa;
  logic [iopt_pkg::CNT_W-1:0] cnt;
  logic                       wr;
  logic [TBL_W-1:0]           tbl;
  logic [TBL_W:0]             nfree;
  logic [iopt_pkg::LVL_W-1:0] level;
  logic [iopt_pkg::PA_W-1:0]  result;
  logic                       err;
  logic [ADDR_W-1:0]          clr_cnt;

  logic [ADDR_W-1:0]          pos;
  logic                       we;
  logic [ADDR_W-1:0]          waddr;
  iopt_pkg::ent_t             wdata;
  iopt_pkg::ent_t             ent_int;
  iopt_pkg::ent_t             ent_leaf;

  assign pos = {tbl, iopt_pkg::slot_index(va, level)};

  always_comb begin
    ent_int         = '0;
    ent_int.present = 1'b1;
    ent_int.perm_r  = 1'b1;
    ent_int.perm_w  = 1'b1;
    ent_int.nxt     = level - 1'b1;
    ent_int.addr    = iopt_pkg::FRAME_W'(nfree[TBL_W-1:0]);

    ent_leaf         = '0;
    ent_leaf.present = 1'b1;
    ent_leaf.perm_r  = 1'b1;
    ent_leaf.perm_w  = wr;
    ent_leaf.addr    = pa[iopt_pkg::PA_W-1:12];

    we    = cmd.clr_step | cmd.alloc | cmd.wr_leaf;
    waddr = cmd.clr_step ? clr_cnt : pos;
    priority if (cmd.clr_step)                   wdata = '0;
    else if (cmd.alloc)                          wdata = ent_int;
    else if (op == iopt_pkg::OP_MAP)             wdata = ent_leaf;
    else                                         wdata = '0;
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (cmd.rd) rdata <= mem[pos];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enable    <= 1'b0;
      nfree     <= (TBL_W + 1)'(1);
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) enable <= cfg_data;
      if (cmd.clr_step) clr_cnt <= clr_cnt + 1'b1;
      if (cmd.alloc) nfree <= nfree + 1'b1;
      if (cmd.finish) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op     <= opcode;
      va     <= io_virtual_address;
      pa     <= physical_address;
      wr     <= write_allowed;
      tbl    <= '0;
      level  <= iopt_pkg::LVL_W'(LEVELS);
      result <= '0;
      err    <= 1'b0;
      if (int'(page_count) > MAX_PAGES) cnt <= iopt_pkg::CNT_W'(MAX_PAGES);
      else                              cnt <= page_count;
    end else begin
      if (cmd.descend) begin
        tbl   <= rdata.addr[TBL_W-1:0];
        level <= level - 1'b1;
      end
      if (cmd.alloc) begin
        tbl   <= nfree[TBL_W-1:0];
        level <= level - 1'b1;
      end
      if (cmd.next_page) begin
        va    <= va + iopt_pkg::VA_W'(4096);
        pa    <= pa + iopt_pkg::PA_W'(4096);
        cnt   <= cnt - 1'b1;
        tbl   <= '0;
        level <= iopt_pkg::LVL_W'(LEVELS);
      end
      if (cmd.set_result) result <= {rdata.addr, va[11:0]};
      if (cmd.set_err) err <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status  <= err;
      out_address <= result;
    end
  end

  always_comb begin
    sts.clr_last   = (clr_cnt == ADDR_W'(DEPTH - 1));
    sts.enable     = enable;
    sts.opcode     = op;
    sts.misaligned = (va[11:0] != 12'd0) || (pa[11:0] != 12'd0);
    sts.count_zero = (cnt == '0);
    sts.count_one  = (cnt == iopt_pkg::CNT_W'(1));
    sts.at_leaf    = (level == iopt_pkg::LVL_W'(1));
    sts.level_two  = (level == iopt_pkg::LVL_W'(2));
    sts.present    = rdata.present;
    sts.link_ok    = (rdata.addr < iopt_pkg::FRAME_W'(TABLE_POOL));
    sts.pool_left  = (int'(nfree) < TABLE_POOL);
    sts.out_free   = !out_valid || out_ready;
  end

endmodule
`default_nettype wire

/* rtl/core/iommu_page_table_walker.sv */
// Top level of the I/O page table walker: controller plus datapath.
// Usage: requests arrive on the req channel (valid/ready) carrying an opcode
// (map, unmap or translate), the I/O virtual address, the physical address,
// a page count and the write permission. Each request yields exactly one
// result on the rsp channel: a status bit and, for translate, the address.
// The single configuration register, enable, is written with cfg_write and
// cfg_data; the user must do so only while the walker is idle, which the block does not enforce.
// A request goes through dispatch and then, for each page of a map or unmap,
// through a read and an evaluation of each table level above the leaf and
// a write of the leaf entry; a translate reads and evaluates every level,
// the leaf included. The result is then loaded into the output register. The
// table memory has a single port with a registered read output. One request is
// handled at a time, and the next one is accepted in the cycle after the result
// is loaded. After reset all TABLE_POOL*512 entries of the table memory are
// cleared one entry per cycle; req.ready stays low during that pass.
// When the receiver stalls, the finished result waits in the output register
// while the next request is accepted; that request then holds at its end
// until the output register frees up.
`timescale 1ns / 1ps
`default_nettype none
module iommu_page_table_walker #(
  parameter int TABLE_POOL = iopt_pkg::DEF_TABLE_POOL,
  parameter int LEVELS     = iopt_pkg::DEF_LEVELS,
  parameter int MAX_PAGES  = iopt_pkg::DEF_MAX_PAGES
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_write,
  input  wire         cfg_data,
  iopt_req_if.sink    req,
  iopt_rsp_if.source  rsp
);

  iopt_pkg::cmd_t cmd;
  iopt_pkg::sts_t sts;

  // The controller sequences the walk and the datapath holds all state.
  iopt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  iopt_dpath #(
    .TABLE_POOL (TABLE_POOL),
    .LEVELS     (LEVELS),
    .MAX_PAGES  (MAX_PAGES)
  ) u_dpath (
    .clk                (clk),
    .rst                (rst),
    .cfg_write          (cfg_write),
    .cfg_data           (cfg_data),
    .opcode             (req.opcode),
    .io_virtual_address (req.io_virtual_address),
    .physical_address   (req.physical_address),
    .page_count         (req.page_count),
    .write_allowed      (req.write_allowed),
    .out_ready          (rsp.ready),
    .out_valid          (rsp.valid),
    .out_status         (rsp.status),
    .out_address        (rsp.translated_address),
    .cmd                (cmd),
    .sts                (sts)
  );

  // The memory has one write port, so at most one writer may act per cycle.
  assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.clr_step, cmd.alloc, cmd.wr_leaf}))
    else $error("table memory write conflict");

  // A table is handed out only while the pool still has one.
  assert property (@(posedge clk) disable iff (rst) cmd.alloc |-> sts.pool_left)
    else $error("allocation beyond the table pool");

  // A result is loaded only when the output register can take it.
  assert property (@(posedge clk) disable iff (rst) cmd.finish |=> rsp.valid)
    else $error("finished request did not reach the output");

  // A new request is taken only after the previous one has finished.
  assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request accepted while busy");

endmodule
`default_nettype wire

/* tb/iommu_page_table_walker_tb.sv */
// Self-checking testbench for the I/O page table walker: directed and random requests against a table model.
`timescale 1ns / 1ps
`default_nettype none
module iommu_page_table_walker_tb;

  localparam int POOL      = iopt_pkg::DEF_TABLE_POOL;
  localparam int NLEVELS   = iopt_pkg::DEF_LEVELS;
  localparam int PAGE_MAX  = iopt_pkg::DEF_MAX_PAGES;
  localparam int SLOTS     = 512;
  // The clearing pass after reset clears POOL*SLOTS entries, and the idle
  // limit is set to four times that.
  localparam int IDLE_LIMIT = 4 * POOL * SLOTS;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [47:0] iova;
    logic [51:0] pa;
    logic [9:0]  count;
    logic        wr;
  } walk_req_t;

  typedef struct packed {
    logic        status;
    logic [51:0] xaddr;
  } walk_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic cfg_data = 1'b0;

  iopt_req_if req ();
  iopt_rsp_if rsp ();

  iommu_page_table_walker DUT (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_data(cfg_data),
    .req(req.sink), .rsp(rsp.source)
  );

  always #5 clk = ~clk;

  // Shadow copy of the page table pool and allocator.
  logic [63:0] pt_shadow [0:POOL*SLOTS-1] = '{default: '0};
  int          next_table = 1;
  logic        unit_on = 1'b0;

  walk_req_t pending_reqs[$];
  walk_rsp_t expected_rsps[$];

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  recv_hold = 1'b0;
  int  errors = 0;
  int  accepted_reqs = 0;
  int  checked_rsps = 0;
  int  idle_cycles = 0;
  int  map_count = 0, unmap_count = 0, xlate_count = 0, fail_count = 0;

  // Walk to the leaf slot of va, growing missing tables when asked.
  function automatic bit find_leaf(input logic [47:0] va, input bit grow,
                                   output int slot);
    int tbl, lvl, pos, fresh;
    logic [63:0] e;
    logic [63:0] t;
    tbl = 0;
    slot = 0;
    for (lvl = NLEVELS; lvl > 1; lvl--) begin
      pos = tbl * SLOTS + int'((va >> (12 + 9 * (lvl - 1))) & 48'h1FF);
      e = pt_shadow[pos];
      if (!e[0]) begin
        if (!grow || next_table >= POOL) return 1'b0;
        fresh = next_table;
        next_table++;
        for (int k = 0; k < SLOTS; k++) pt_shadow[fresh * SLOTS + k] = '0;
        pt_shadow[pos] = (64'(fresh) << 12) | 64'h1 | (64'h1 << 61) | (64'h1 << 62)
                         | (64'(lvl - 1) << 9);
        tbl = fresh;
      end else begin
        t = (e & 64'h000F_FFFF_FFFF_F000) >> 12;
        if (t >= 64'(POOL)) return 1'b0;
        tbl = int'(t);
      end
    end
    slot = tbl * SLOTS + int'((va >> 12) & 48'h1FF);
    return 1'b1;
  endfunction

  // Predict the response to one request and update the shadow table.
  function automatic walk_rsp_t predict_walk(input walk_req_t r);
    walk_rsp_t o;
    int cnt, slot;
    logic [47:0] pva;
    logic [51:0] ppa;
    logic [63:0] e;
    o = '0;
    cnt = (r.count > PAGE_MAX) ? PAGE_MAX : int'(r.count);
    if (!unit_on || r.opcode == iopt_pkg::OP_BAD) begin
      o.status = 1'b1;
    end else if (r.opcode == iopt_pkg::OP_MAP) begin
      if (r.iova[11:0] != 0 || r.pa[11:0] != 0) begin
        o.status = 1'b1;
      end else begin
        for (int i = 0; i < cnt; i++) begin
          pva = r.iova + 48'(i) * 48'd4096;
          ppa = r.pa + 52'(i) * 52'd4096;
          if (!find_leaf(pva, 1'b1, slot)) begin
            o.status = 1'b1;
            break;
          end
          pt_shadow[slot] = {12'b0, ppa[51:12], 12'b0} | 64'h1 | (64'h1 << 61)
                            | (r.wr ? (64'h1 << 62) : 64'h0);
        end
      end
    end else if (r.opcode == iopt_pkg::OP_UNMAP) begin
      for (int i = 0; i < cnt; i++) begin
        pva = r.iova + 48'(i) * 48'd4096;
        if (find_leaf(pva, 1'b0, slot)) pt_shadow[slot] = '0;
      end
    end else begin
      if (find_leaf({r.iova[47:12], 12'b0}, 1'b0, slot)) begin
        e = pt_shadow[slot];
        if (e[0]) o.xaddr = {e[51:12], r.iova[11:0]};
      end
    end
    return o;
  endfunction

  // Driver: offers the head of the pending queue, idling at random.
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
      {req.opcode, req.io_virtual_address, req.physical_address,
       req.page_count, req.write_allowed} <= '0;
    end else begin
      if (req.valid && req.ready) begin
        expected_rsps.push_back(predict_walk(pending_reqs.pop_front()));
        accepted_reqs++;
      end
      if ((!req.valid || req.ready) ) begin
        if (pending_reqs.size() > 0 && ($urandom_range(99) >= send_idle_pct)) begin
          req.valid <= 1'b1;
          {req.opcode, req.io_virtual_address, req.physical_address,
           req.page_count, req.write_allowed} <= pending_reqs[0];
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: takes responses with random stalls and checks them in order.
  always @(posedge clk) begin
    walk_rsp_t exp_rsp;
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected response status=%0b addr=%h", $time,
                   rsp.status, rsp.translated_address);
          errors++;
        end else begin
          exp_rsp = expected_rsps.pop_front();
          checked_rsps++;
          if (exp_rsp.status !== rsp.status) begin
            $display("%0t: status expected %0b actual %0b", $time,
                     exp_rsp.status, rsp.status);
            errors++;
          end
          if (exp_rsp.xaddr !== rsp.translated_address) begin
            $display("%0t: address expected %h actual %h", $time,
                     exp_rsp.xaddr, rsp.translated_address);
            errors++;
          end
        end
      end
      rsp.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("Timeout after %0d idle cycles", idle_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic queue_req(input logic [1:0] op, input logic [47:0] va,
                           input logic [51:0] pa, input logic [9:0] cnt,
                           input logic wr);
    walk_req_t r;
    r = '{opcode: op, iova: va, pa: pa, count: cnt, wr: wr};
    pending_reqs.push_back(r);
    case (op)
      iopt_pkg::OP_MAP:   map_count++;
      iopt_pkg::OP_UNMAP: unmap_count++;
      iopt_pkg::OP_XLATE: xlate_count++;
      default:            fail_count++;
    endcase
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || expected_rsps.size() > 0) @(posedge clk);
    // A request whose response is still in flight is impossible here, so a
    // short settling pause suffices before touching the register.
    repeat (20) @(posedge clk);
  endtask

  task automatic set_unit(input logic on);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= on;
    @(posedge clk);
    cfg_write <= 1'b0;
    unit_on = on;
  endtask

  // Random requests: mostly clustered well-formed maps and translates inside
  // a few small windows, so walks reuse tables and the pool fills slowly.
  task automatic random_reqs(input int n);
    logic [47:0] va;
    logic [51:0] pa;
    logic [9:0]  cnt;
    int          pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      va = {$urandom_range(3) == 0 ? 16'($urandom) : 16'h0, 32'($urandom)};
      va[47:30] = {16'($urandom_range(2)), 2'($urandom)};
      va[11:0] = 12'h0;
      pa = {20'($urandom), 32'($urandom)};
      pa[11:0] = 12'h0;
      cnt = ($urandom_range(19) == 0) ? 10'($urandom) : 10'($urandom_range(4));
      if (pick < 35) begin
        if ($urandom_range(15) == 0) va[11:0] = 12'($urandom);
        if ($urandom_range(15) == 0) pa[11:0] = 12'($urandom);
        queue_req(iopt_pkg::OP_MAP, va, pa, cnt, 1'($urandom));
      end else if (pick < 50) begin
        queue_req(iopt_pkg::OP_UNMAP, va, pa, cnt, 1'($urandom));
      end else if (pick < 97) begin
        va[11:0] = 12'($urandom);
        queue_req(iopt_pkg::OP_XLATE, va, pa, cnt, 1'($urandom));
      end else begin
        queue_req(iopt_pkg::OP_BAD, va, pa, cnt, 1'($urandom));
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Disabled unit: every opcode fails without touching the table.
    queue_req(iopt_pkg::OP_MAP, 48'h0, 52'h0, 10'd1, 1'b1);
    queue_req(iopt_pkg::OP_XLATE, 48'h123, 52'h0, 10'd0, 1'b0);
    queue_req(iopt_pkg::OP_UNMAP, 48'h0, 52'h0, 10'd1, 1'b0);
    queue_req(iopt_pkg::OP_BAD, 48'h0, 52'h0, 10'd1, 1'b0);
    wait_drained();
    set_unit(1'b1);

    // Directed: extremes, misalignment, zero and saturated counts, wrap.
    queue_req(iopt_pkg::OP_MAP, 48'h0, 52'hF_FFFF_FFFF_F000, 10'd2, 1'b1);
    queue_req(iopt_pkg::OP_XLATE, 48'h0FFF, 52'h0, 10'd0, 1'b0);
    queue_req(iopt_pkg::OP_XLATE, 48'h1ABC, 52'h0, 10'd0, 1'b0);
    queue_req(iopt_pkg::OP_MAP, 48'hFFFF_FFFF_F000, 52'h0000_0000_5000, 10'd2, 1'b0);
    queue_req(iopt_pkg::OP_XLATE, 48'hFFFF_FFFF_FFFF, 52'h0, 10'd0, 1'b1);
    queue_req(iopt_pkg::OP_XLATE, 48'h0000_0000_0FFF, 52'h0, 10'd0, 1'b1);
    queue_req(iopt_pkg::OP_MAP, 48'h0000_0040_0001, 52'h0, 10'd1, 1'b1);
    queue_req(iopt_pkg::OP_MAP, 48'h0000_0040_0000, 52'h0000_0000_0800, 10'd1, 1'b1);
    queue_req(iopt_pkg::OP_MAP, 48'h0000_0080_0000, 52'h0, 10'd0, 1'b1);
    queue_req(iopt_pkg::OP_MAP, 48'h0000_1000_0000, 52'h1234_5678_9000, 10'h3FF, 1'b1);
    queue_req(iopt_pkg::OP_XLATE, 48'h0000_1000_0FFF, 52'h0, 10'd0, 1'b0);
    queue_req(iopt_pkg::OP_XLATE, 48'h0000_101F_F123, 52'h0, 10'd0, 1'b0);
    queue_req(iopt_pkg::OP_XLATE, 48'h0000_1020_0000, 52'h0, 10'd0, 1'b0);
    queue_req(iopt_pkg::OP_UNMAP, 48'h0000_1000_0000, 52'h0, 10'd3, 1'b0);
    queue_req(iopt_pkg::OP_XLATE, 48'h0000_1000_1000, 52'h0, 10'd0, 1'b0);
    queue_req(iopt_pkg::OP_UNMAP, 48'h7777_0000_0000, 52'h0, 10'd2, 1'b0);
    queue_req(iopt_pkg::OP_XLATE, 48'h8000_0000_0000, 52'h0, 10'd0, 1'b0);
    queue_req(iopt_pkg::OP_BAD, 48'hFFFF_FFFF_FFFF, 52'hF_FFFF_FFFF_FFFF, 10'h3FF, 1'b1);

    // Sender idles 27%, receiver 48%.
    send_idle_pct = 27;
    recv_idle_pct = 48;
    random_reqs(380);
    // Long receiver hold-off while requests keep coming.
    recv_hold = 1'b1;
    repeat (300) @(posedge clk);
    recv_hold = 1'b0;
    wait_drained();

    // Turn the unit off briefly and back on between phases.
    set_unit(1'b0);
    random_reqs(20);
    wait_drained();
    set_unit(1'b1);

    send_idle_pct = 48;
    recv_idle_pct = 27;
    random_reqs(380);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    // Scattered maps to run the table pool dry.
    for (int i = 0; i < 60; i++)
      queue_req(iopt_pkg::OP_MAP, {9'(i), 9'($urandom), 9'($urandom), 21'h0},
                {20'($urandom), 20'($urandom), 12'h0}, 10'd2, 1'b1);
    random_reqs(300);
    wait_drained();

    $display("Covered %0d requests (%0d map, %0d unmap, %0d translate, %0d bad op),",
             accepted_reqs, map_count, unmap_count, xlate_count, fail_count);
    $display("%0d responses checked, %0d of %0d tables allocated.", checked_rsps,
             next_table, POOL);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
`default_nettype wire
